// File: rtl/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg: shared types and constants of the max frequency stack
// Operation and status codes, the per-cycle command of the cell chain and
// an elaboration helper for the push value reduction.
// ----------------------------------------------------------------------------
package mfs_pkg;

  // widths fixed by the stream payload
  localparam int VAL_IN_W  = 10;
  localparam int STATUS_W  = 2;
  localparam int TDATA_W   = 16;

  // operation carried in tuser on the input side
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // status carried in tuser on the output side
  typedef enum logic [STATUS_W-1:0] {
    ST_POPPED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } cmd_t;

  // number of compare-subtract steps that bring an input value below vc
  function automatic int red_steps(int vc);
    int n;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if ((longint'(vc) << i) <= longint'((1 << VAL_IN_W) - 1)) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

endpackage

// File: rtl/mfs_cell.sv
// ----------------------------------------------------------------------------
// mfs_cell: one slot of the sorted entry chain
// Holds one (value, count) entry. On push it keeps its entry, takes the new
// one or takes its upper neighbor's; on pop it takes its lower neighbor's.
// ----------------------------------------------------------------------------
module mfs_cell #(
  parameter int VAL_W = 10,
  parameter int CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mfs_pkg::cmd_t    cmd_i,
  input  logic [VAL_W-1:0] new_val_i,
  input  logic [CNT_W-1:0] new_cnt_i,
  // neighbor toward the top of the chain
  input  logic             prev_greater_i,
  input  logic             prev_valid_i,
  input  logic [VAL_W-1:0] prev_val_i,
  input  logic [CNT_W-1:0] prev_cnt_i,
  // neighbor toward the bottom of the chain
  input  logic             next_valid_i,
  input  logic [VAL_W-1:0] next_val_i,
  input  logic [CNT_W-1:0] next_cnt_i,
  output logic             greater_o,
  output logic             valid_o,
  output logic [VAL_W-1:0] val_o,
  output logic [CNT_W-1:0] cnt_o
);

  logic             valid_q, valid_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             load;

  // entry ranks above the new one: keep it in place
  assign greater_o = valid_q && (cnt_q > new_cnt_i);

  // next entry selection
  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    load    = 1'b0;
    if (cmd_i.pop) begin
      valid_d = next_valid_i;
      val_d   = next_val_i;
      cnt_d   = next_cnt_i;
      load    = 1'b1;
    end else if (cmd_i.push && !greater_o) begin
      load = 1'b1;
      if (prev_greater_i) begin
        valid_d = 1'b1;
        val_d   = new_val_i;
        cnt_d   = new_cnt_i;
      end else begin
        valid_d = prev_valid_i;
        val_d   = prev_val_i;
        cnt_d   = prev_cnt_i;
      end
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      val_q <= val_d;
      cnt_q <= cnt_d;
    end
  end

  assign valid_o = valid_q;
  assign val_o   = val_q;
  assign cnt_o   = cnt_q;

endmodule

// File: rtl/mfs_count_mem.sv
// ----------------------------------------------------------------------------
// mfs_count_mem: occurrence count memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfs_count_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/max_frequency_stack.sv
// ----------------------------------------------------------------------------
// max_frequency_stack: push / pop store returning the most frequent value
// Entries sit in a chain of cells sorted by count, top of the chain first;
// occurrence counts live in a one-port-read memory.
// ----------------------------------------------------------------------------
// A push (tuser 0) raises the value's count and inserts it into the chain;
// a pop (tuser 1) returns the highest-count entry, the latest push winning
// ties, with status in m_axis_tuser_o. A successful push returns no word.
// In S_IDLE the accept cycle issues the count memory read; for a pop, or a
// push when VALUE_COUNT is at least 1024, the next cycle writes the new count
// and shifts the cell chain. Below 1024 a push first runs the compare-subtract
// steps of the value reduction in S_REDUCE and reads the reduced value's count
// in S_READ. After reset the count memory is cleared one entry a cycle, and
// no word is accepted until every entry is cleared.
module max_frequency_stack #(
  parameter int VALUE_COUNT = 1024,
  parameter int CAPACITY    = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [mfs_pkg::TDATA_W-1:0]  s_axis_tdata_i,  // value[9:0], zero pad
  input  logic                         s_axis_tuser_i,  // operation
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [mfs_pkg::TDATA_W-1:0]  m_axis_tdata_o,  // popped_value[9:0], zero pad
  output logic [mfs_pkg::STATUS_W-1:0] m_axis_tuser_o   // status
);

  localparam int VAL_W     = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IN_W      = mfs_pkg::VAL_IN_W;
  localparam int WIDE_W    = (VAL_W > IN_W) ? VAL_W : IN_W;
  localparam int RED_STEPS = mfs_pkg::red_steps(VALUE_COUNT);
  localparam int K_W       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_READ,
    S_UPDATE
  } state_e;

  state_e                   state_q;
  mfs_pkg::op_e             op_q;
  logic [VAL_W-1:0]         addr_q;
  logic [IN_W-1:0]          red_q;
  logic [K_W-1:0]           k_q;
  logic [VAL_W-1:0]         clr_q;
  logic                     out_valid_q;
  mfs_pkg::status_e         out_status_q;
  logic [IN_W-1:0]          out_val_q;

  logic                     in_accept;
  mfs_pkg::op_e             in_op;
  logic [WIDE_W-1:0]        in_wide;
  logic [VAL_W-1:0]         in_val;
  logic [WIDE_W-1:0]        red_wide;
  logic [VAL_W-1:0]         red_val;
  logic [31:0]              red_lim;
  logic                     red_ge;
  logic [IN_W-1:0]          red_next;
  logic [WIDE_W-1:0]        top_wide;
  logic [IN_W-1:0]          top_val_out;

  logic                     mem_we;
  logic [VAL_W-1:0]         mem_waddr;
  logic [CNT_W-1:0]         mem_wdata;
  logic [VAL_W-1:0]         mem_raddr;
  logic [CNT_W-1:0]         mem_rdata;
  logic [CNT_W-1:0]         cnt_inc;
  logic [CNT_W-1:0]         cnt_dec;

  logic                     chain_full;
  logic                     chain_empty;
  mfs_pkg::cmd_t            chain_cmd;

  logic [CAPACITY-1:0]      cell_valid;
  logic [CAPACITY-1:0]      cell_greater;
  logic [VAL_W-1:0]         cell_val [CAPACITY];
  logic [CNT_W-1:0]         cell_cnt [CAPACITY];

  // input side decode
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op     = mfs_pkg::op_e'(s_axis_tuser_i);
  assign in_wide   = WIDE_W'(s_axis_tdata_i[IN_W-1:0]);
  assign in_val    = in_wide[VAL_W-1:0];
  assign red_wide  = WIDE_W'(red_q);
  assign red_val   = red_wide[VAL_W-1:0];
  assign top_wide  = WIDE_W'(cell_val[0]);
  assign top_val_out = top_wide[IN_W-1:0];

  // one compare-subtract step of the value reduction
  assign red_lim  = 32'(VALUE_COUNT) << k_q;
  assign red_ge   = 32'(red_q) >= red_lim;
  assign red_next = red_ge ? IN_W'(32'(red_q) - red_lim) : red_q;

  // chain status and command
  assign chain_full  = cell_valid[CAPACITY-1];
  assign chain_empty = !cell_valid[0];
  assign chain_cmd.push = (state_q == S_UPDATE) && (op_q == mfs_pkg::OP_PUSH) && !chain_full;
  assign chain_cmd.pop  = (state_q == S_UPDATE) && (op_q == mfs_pkg::OP_POP) && !chain_empty;

  // count update values
  assign cnt_inc = mem_rdata + CNT_W'(1);
  assign cnt_dec = (mem_rdata != '0) ? (mem_rdata - CNT_W'(1)) : '0;

  // count memory read address
  always_comb begin
    unique case (state_q)
      S_IDLE:  mem_raddr = (in_op == mfs_pkg::OP_POP) ? cell_val[0] : in_val;
      S_READ:  mem_raddr = red_val;
      default: mem_raddr = addr_q;
    endcase
  end

  // count memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (chain_cmd.push) begin
      mem_we    = 1'b1;
      mem_wdata = cnt_inc;
    end else if (chain_cmd.pop) begin
      mem_we    = 1'b1;
      mem_wdata = cnt_dec;
    end
  end

  mfs_count_mem #(
    .DEPTH  (VALUE_COUNT),
    .ADDR_W (VAL_W),
    .DATA_W (CNT_W)
  ) u_count_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sorted cell chain, cell 0 holds the top entry
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             prev_greater;
    logic             prev_valid;
    logic [VAL_W-1:0] prev_val;
    logic [CNT_W-1:0] prev_cnt;
    logic             next_valid;
    logic [VAL_W-1:0] next_val;
    logic [CNT_W-1:0] next_cnt;

    if (i == 0) begin : g_first
      assign prev_greater = 1'b1;
      assign prev_valid   = 1'b0;
      assign prev_val     = '0;
      assign prev_cnt     = '0;
    end else begin : g_mid
      assign prev_greater = cell_greater[i-1];
      assign prev_valid   = cell_valid[i-1];
      assign prev_val     = cell_val[i-1];
      assign prev_cnt     = cell_cnt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_val   = '0;
      assign next_cnt   = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_val   = cell_val[i+1];
      assign next_cnt   = cell_cnt[i+1];
    end

    mfs_cell #(
      .VAL_W (VAL_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (chain_cmd),
      .new_val_i      (addr_q),
      .new_cnt_i      (cnt_inc),
      .prev_greater_i (prev_greater),
      .prev_valid_i   (prev_valid),
      .prev_val_i     (prev_val),
      .prev_cnt_i     (prev_cnt),
      .next_valid_i   (next_valid),
      .next_val_i     (next_val),
      .next_cnt_i     (next_cnt),
      .greater_o      (cell_greater[i]),
      .valid_o        (cell_valid[i]),
      .val_o          (cell_val[i]),
      .cnt_o          (cell_cnt[i])
    );
  end

  // sequencer and output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      op_q         <= mfs_pkg::OP_PUSH;
      addr_q       <= '0;
      red_q        <= '0;
      k_q          <= '0;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= mfs_pkg::ST_POPPED;
      out_val_q    <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + VAL_W'(1);
          if (clr_q == VAL_W'(VALUE_COUNT - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            op_q   <= in_op;
            red_q  <= s_axis_tdata_i[IN_W-1:0];
            addr_q <= mem_raddr;
            k_q    <= K_W'(RED_STEPS - 1);
            if (in_op == mfs_pkg::OP_POP || RED_STEPS == 0) begin
              state_q <= S_UPDATE;
            end else begin
              state_q <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          red_q <= red_next;
          if (k_q == '0) begin
            state_q <= S_READ;
          end else begin
            k_q <= k_q - K_W'(1);
          end
        end
        S_READ: begin
          addr_q  <= mem_raddr;
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          if (op_q == mfs_pkg::OP_POP) begin
            out_valid_q  <= 1'b1;
            out_status_q <= chain_empty ? mfs_pkg::ST_EMPTY : mfs_pkg::ST_POPPED;
            out_val_q    <= chain_empty ? '0 : top_val_out;
          end else if (chain_full) begin
            out_valid_q  <= 1'b1;
            out_status_q <= mfs_pkg::ST_FULL;
            out_val_q    <= '0;
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // stream ports
  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = mfs_pkg::TDATA_W'(out_val_q);
  assign m_axis_tuser_o  = out_status_q;

`ifndef ASSERT_OFF
  // valid cells always form an unbroken run from the top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("cell chain has a hole");

  // the top entry never ranks below the one after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> (cell_cnt[0] >= cell_cnt[1]))
    else $error("cell chain out of order");

  // a word is never accepted in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready_o)
    else $error("input accepted while an item is in flight");

  // a pushed count is always nonzero when written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_cmd.push |-> (mem_wdata != '0))
    else $error("push wrote a zero count");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the max frequency stack
// Push and pop words go in on the slave stream, and replies are checked on the
// master stream against a scoreboard that keeps its own count table and
// sorted entry chain. Both sides idle in random bursts. One long output
// hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int VALUE_COUNT  = 1024;
  localparam int CAPACITY     = 64;
  localparam int CNT_W        = 7;
  localparam int RANDOM_WORDS = 1100;
  localparam int CALM_WORDS   = 150;
  localparam int HOLD_AT      = 300;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    mfs_pkg::status_e             status;
    logic [mfs_pkg::VAL_IN_W-1:0] value;
  } reply_t;

  // scoreboard: tracks counts and the sorted chain, queues expected replies
  class stack_scoreboard;
    logic [CNT_W-1:0]             freq [VALUE_COUNT];
    logic [mfs_pkg::VAL_IN_W-1:0] chain_val [CAPACITY];
    logic [CNT_W-1:0]             chain_cnt [CAPACITY];
    int                           occupancy;
    reply_t                       pending_replies [$];
    int                           errors;
    int                           n_pushed;
    int                           n_popped;
    int                           n_empty;
    int                           n_full;

    function new();
      foreach (freq[i]) freq[i] = '0;
      foreach (chain_val[i]) begin
        chain_val[i] = '0;
        chain_cnt[i] = '0;
      end
      occupancy = 0;
      errors    = 0;
      n_pushed  = 0;
      n_popped  = 0;
      n_empty   = 0;
      n_full    = 0;
    endfunction

    // apply one accepted word to the shadow state
    function void note_word(mfs_pkg::op_e op, logic [mfs_pkg::VAL_IN_W-1:0] raw);
      reply_t r;
      int     v;
      int     c;
      int     pos;
      if (op == mfs_pkg::OP_PUSH) begin
        if (occupancy >= CAPACITY) begin
          r.status = mfs_pkg::ST_FULL;
          r.value  = '0;
          pending_replies.push_back(r);
          n_full++;
        end else begin
          v = int'(raw) % VALUE_COUNT;
          c = int'(freq[v]) + 1;
          freq[v] = CNT_W'(c);
          // entries with count <= c form the lower part of the chain
          pos = 0;
          while (pos < occupancy && int'(chain_cnt[pos]) <= c) pos++;
          for (int i = occupancy; i > pos; i--) begin
            chain_val[i] = chain_val[i-1];
            chain_cnt[i] = chain_cnt[i-1];
          end
          chain_val[pos] = mfs_pkg::VAL_IN_W'(v);
          chain_cnt[pos] = CNT_W'(c);
          occupancy++;
          n_pushed++;
        end
      end else begin
        if (occupancy == 0) begin
          r.status = mfs_pkg::ST_EMPTY;
          r.value  = '0;
          n_empty++;
        end else begin
          occupancy--;
          v = int'(chain_val[occupancy]) % VALUE_COUNT;
          if (freq[v] != '0) freq[v] = freq[v] - CNT_W'(1);
          r.status = mfs_pkg::ST_POPPED;
          r.value  = mfs_pkg::VAL_IN_W'(v);
          n_popped++;
        end
        pending_replies.push_back(r);
      end
    endfunction

    // compare one output word with the oldest expected reply
    function void check_word(logic [mfs_pkg::STATUS_W-1:0] st,
                             logic [mfs_pkg::TDATA_W-1:0] data);
      reply_t exp_r;
      if (pending_replies.size() == 0) begin
        $error("unexpected output word: status %0d, popped_value %0d", st, data);
        errors++;
        return;
      end
      exp_r = pending_replies.pop_front();
      if (st !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, st);
        errors++;
      end
      if (data !== mfs_pkg::TDATA_W'(exp_r.value)) begin
        $error("popped_value: expected %0d, actual %0d", exp_r.value, data);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_valid;
  logic [mfs_pkg::TDATA_W-1:0]  s_data;
  logic                         s_user;
  logic                         m_ready;
  logic                         s_axis_tready_o;
  logic                         m_axis_tvalid_o;
  logic [mfs_pkg::TDATA_W-1:0]  m_axis_tdata_o;
  logic [mfs_pkg::STATUS_W-1:0] m_axis_tuser_o;

  bit                           calm;
  bit                           long_hold_req;
  logic [mfs_pkg::VAL_IN_W-1:0] hot_vals [4];

  stack_scoreboard sb = new();

  max_frequency_stack #(
    .VALUE_COUNT (VALUE_COUNT),
    .CAPACITY    (CAPACITY)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 50 MHz clock
  always #10 clk_i = ~clk_i;

  // monitor both streams at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (s_valid && s_axis_tready_o === 1'b1) begin
        sb.note_word(mfs_pkg::op_e'(s_user), s_data[mfs_pkg::VAL_IN_W-1:0]);
      end
      if (m_axis_tvalid_o === 1'b1 && m_ready) sb.check_word(m_axis_tuser_o, m_axis_tdata_o);
    end
  end

  // hot values give high counts and ties, the rest covers the full range
  function automatic logic [mfs_pkg::VAL_IN_W-1:0] pick_value();
    unique case ($urandom_range(0, 3))
      0, 1:    return hot_vals[$urandom_range(0, 3)];
      2:       return mfs_pkg::VAL_IN_W'($urandom_range(0, VALUE_COUNT - 1));
      default: return $urandom_range(0, 1) ? {mfs_pkg::VAL_IN_W{1'b1}}
                                           : {mfs_pkg::VAL_IN_W{1'b0}};
    endcase
  endfunction

  // offer one word, possibly after an idle burst, and wait for acceptance
  task automatic send_word(input mfs_pkg::op_e op,
                           input logic [mfs_pkg::VAL_IN_W-1:0] v);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(mfs_pkg::TDATA_W - mfs_pkg::VAL_IN_W){1'b0}}, v};
    s_user  <= op;
    @(posedge clk_i);
    while (s_axis_tready_o !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // output side ready: random stall bursts plus one long hold-off
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 0;
    m_ready    = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else if (long_hold_req && !hold_done) begin
        hold_done  = 1;
        stall_left = LONG_HOLD - 1;
        m_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // cycle limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $error("timeout after %0d cycles", cycles);
    $display("== FAIL ==");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int mode;
    int phase_len;
    int pop_pct;
    int sent;
    int fails;
    bit first;
    rst_ni  = 1'b0;
    s_valid = 1'b0;
    s_data  = '0;
    s_user  = mfs_pkg::OP_PUSH;
    calm    = 0;
    long_hold_req = 0;
    foreach (hot_vals[i]) hot_vals[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty pops, extreme values, ties broken by recency
    send_word(mfs_pkg::OP_POP, 10'h000);
    send_word(mfs_pkg::OP_POP, 10'h3FF);
    send_word(mfs_pkg::OP_PUSH, 10'h000);
    send_word(mfs_pkg::OP_PUSH, 10'h3FF);
    send_word(mfs_pkg::OP_PUSH, 10'h3FF);
    send_word(mfs_pkg::OP_PUSH, 10'h155);
    send_word(mfs_pkg::OP_PUSH, 10'h000);
    send_word(mfs_pkg::OP_PUSH, 10'h2AA);
    send_word(mfs_pkg::OP_PUSH, 10'h3FF);
    send_word(mfs_pkg::OP_POP, 10'h155);
    send_word(mfs_pkg::OP_POP, 10'h000);
    send_word(mfs_pkg::OP_POP, 10'h000);
    send_word(mfs_pkg::OP_PUSH, 10'h155);
    send_word(mfs_pkg::OP_PUSH, 10'h155);
    send_word(mfs_pkg::OP_POP, 10'h000);
    send_word(mfs_pkg::OP_POP, 10'h000);
    send_word(mfs_pkg::OP_POP, 10'h000);
    send_word(mfs_pkg::OP_POP, 10'h000);
    send_word(mfs_pkg::OP_POP, 10'h000);
    send_word(mfs_pkg::OP_POP, 10'h000);
    send_word(mfs_pkg::OP_POP, 10'h000);

    // random phases: the first fills the store past full to hit dropped pushes
    sent  = 0;
    first = 1;
    while (sent < RANDOM_WORDS) begin
      mode      = first ? 0 : $urandom_range(0, 2);
      phase_len = first ? 100 : $urandom_range(20, 100);
      foreach (hot_vals[i]) begin
        hot_vals[i] = mfs_pkg::VAL_IN_W'($urandom_range(0, VALUE_COUNT - 1));
      end
      unique case (mode)
        0:       pop_pct = first ? 5 : 15;
        1:       pop_pct = 85;
        default: pop_pct = 50;
      endcase
      for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
        calm = (sent >= RANDOM_WORDS - CALM_WORDS);
        if (sent == HOLD_AT) long_hold_req = 1;
        if ($urandom_range(0, 99) < pop_pct) begin
          send_word(mfs_pkg::OP_POP,
                    mfs_pkg::VAL_IN_W'($urandom_range(0, VALUE_COUNT - 1)));
        end else begin
          send_word(mfs_pkg::OP_PUSH, pick_value());
        end
        sent++;
      end
      first = 0;
    end
    s_valid <= 1'b0;

    // drain the replies, then watch for stray words
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    fails = sb.errors;
    if (sb.pending_replies.size() != 0) begin
      $error("%0d expected replies never arrived", sb.pending_replies.size());
      fails++;
    end
    $display("run covered %0d stored pushes, %0d pops with a value, %0d empty pops,",
             sb.n_pushed, sb.n_popped, sb.n_empty);
    $display("%0d pushes dropped on a full store and one long output hold-off", sb.n_full);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
